@@ rtl/psmd_pkg.sv @@
// Shared types and constants for the pot smoothing motion detector.
package psmd_pkg;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_RESET = 2'd1,
    OP_ARM   = 2'd2
  } op_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_FRAMES    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PADDLE_RANGE   = 2'd2;

  localparam int unsigned THRESH_W = 12;
  localparam int unsigned HOLD_W   = 6;
  localparam int unsigned RANGE_W  = 12;
  localparam int unsigned FIELD_W  = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd40;
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = 6'd20;
  localparam logic [RANGE_W-1:0]  RANGE_RESET  = 12'd240;

  localparam int unsigned FULL_SCALE    = 4095;
  localparam int unsigned SMOOTH_WEIGHT = 3;

endpackage

@@ rtl/psmd_channel.sv @@
// One pot channel: first-order smoothing and baseline change test.
module psmd_channel #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0]           smooth_old,
  input  logic [SAMPLE_BITS-1:0]           baseline,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [psmd_pkg::THRESH_W-1:0]    threshold,
  output logic [SAMPLE_BITS-1:0]           smooth_new,
  output logic                             moved
);

  localparam int unsigned SUM_W = SAMPLE_BITS + 2;
  localparam int unsigned CMP_W = SAMPLE_BITS + psmd_pkg::THRESH_W;

  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] diff;

  assign sum = SUM_W'(smooth_old) * SUM_W'(psmd_pkg::SMOOTH_WEIGHT) + SUM_W'(sample);
  assign smooth_new = sum[SUM_W-1:2];

  assign diff = (smooth_new >= baseline) ? (smooth_new - baseline) : (baseline - smooth_new);
  assign moved = CMP_W'(diff) > CMP_W'(threshold);

endmodule

@@ rtl/psmd_scale.sv @@
// Paddle position: floor(value * range / 4095), clamped to range.
module psmd_scale #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0]          value,
  input  logic [psmd_pkg::RANGE_W-1:0]    range,
  output logic [psmd_pkg::FIELD_W-1:0]    paddle
);

  localparam int unsigned PW = SAMPLE_BITS + psmd_pkg::RANGE_W;

  logic [PW-1:0] prod;
  logic [PW-1:0] hi1, lo1, t1, hi2, lo2, t2, quot, clamped;

  assign prod = PW'(value) * PW'(range);

  // 4096 = 4095 + 1: fold the high part back in twice, then one compare
  assign hi1 = prod >> 12;
  assign lo1 = prod & PW'(psmd_pkg::FULL_SCALE);
  assign t1  = hi1 + lo1;
  assign hi2 = t1 >> 12;
  assign lo2 = t1 & PW'(psmd_pkg::FULL_SCALE);
  assign t2  = hi2 + lo2;
  assign quot = hi1 + hi2 + PW'(t2 >= PW'(psmd_pkg::FULL_SCALE));

  assign clamped = (quot > PW'(range)) ? PW'(range) : quot;
  assign paddle  = clamped[psmd_pkg::FIELD_W-1:0];

endmodule

@@ rtl/pot_smoothing_motion_detector.sv @@
// Top level of the pot smoothing motion detector.
//
//  channel  direction  handshake             payload
//  in_      sink       in_valid / in_ready   operation, two samples, pin, query
//  out_     source     out_valid / out_ready value, paddle, movement, mover, edge
//  cfg_     sink       cfg_valid / cfg_ready register index, write data
//
// State updates at the beat an item is accepted; the result passes through the stage register,
// then the paddle multiply-divide into the output register. One item per cycle
// unless the output stalls; the paddle multiplier sets the stage 2 path.
// rst_n (synchronous) restores registers and filter state; cfg_ready stays high.
// A stalled output holds both stages; in_ready drops only when both are full.
module pot_smoothing_motion_detector #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [SAMPLE_BITS-1:0]              in_sample_p1,
  input  logic [SAMPLE_BITS-1:0]              in_sample_p2,
  input  logic                                in_button_pin_level,
  input  logic                                in_query_player,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [SAMPLE_BITS-1:0]              out_smoothed_value,
  output logic [psmd_pkg::FIELD_W-1:0]        out_paddle_y,
  output logic                                out_movement_detected,
  output logic                                out_last_mover,
  output logic                                out_press_edge,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [psmd_pkg::FIELD_W-1:0]        cfg_data
);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  logic [psmd_pkg::THRESH_W-1:0] thresh_r;
  logic [psmd_pkg::HOLD_W-1:0]   hold_frames_r;
  logic [psmd_pkg::RANGE_W-1:0]  range_r;

  logic [SAMPLE_BITS-1:0] smooth_r [2];
  logic [SAMPLE_BITS-1:0] base_r   [2];
  logic [SAMPLE_BITS-1:0] smooth_nxt [2];
  logic [SAMPLE_BITS-1:0] base_nxt   [2];
  logic [SAMPLE_BITS-1:0] filt [2];
  logic                   moved [2];
  logic [psmd_pkg::HOLD_W-1:0] hold_r, hold_nxt, hold_load;
  logic mover_r, mover_nxt, prev_r, prev_nxt, edge_r, edge_nxt;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_value_r;
  logic                   s1_move_r, s1_mover_r, s1_edge_r;

  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_value_r;
  logic [psmd_pkg::FIELD_W-1:0]  out_paddle_r;
  logic                          out_move_r, out_mover_r, out_edge_r;
  logic [psmd_pkg::FIELD_W-1:0]  paddle;

  logic in_fire, s2_adv;
  psmd_pkg::op_t op;

  assign op        = psmd_pkg::op_t'(in_operation);
  assign s2_adv    = out_ready || !out_valid_r;
  assign in_ready  = !s1_valid_r || s2_adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  psmd_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_ch0 (
    .smooth_old (smooth_r[0]),
    .baseline   (base_r[0]),
    .sample     (in_sample_p1),
    .threshold  (thresh_r),
    .smooth_new (filt[0]),
    .moved      (moved[0])
  );

  psmd_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_ch1 (
    .smooth_old (smooth_r[1]),
    .baseline   (base_r[1]),
    .sample     (in_sample_p2),
    .threshold  (thresh_r),
    .smooth_new (filt[1]),
    .moved      (moved[1])
  );

  always_comb begin
    smooth_nxt = smooth_r;
    base_nxt   = base_r;
    hold_nxt   = hold_r;
    mover_nxt  = mover_r;
    prev_nxt   = prev_r;
    edge_nxt   = edge_r;
    hold_load  = hold_r;
    unique case (op)
      psmd_pkg::OP_POLL: begin
        smooth_nxt = filt;
        if (moved[0]) begin
          base_nxt[0] = filt[0];
        end
        if (moved[1]) begin
          base_nxt[1] = filt[1];
        end
        if (moved[0] || moved[1]) begin
          hold_load = hold_frames_r;
        end
        // channel 1 is checked first, so it wins ties
        if (moved[1]) begin
          mover_nxt = 1'b1;
        end else if (moved[0]) begin
          mover_nxt = 1'b0;
        end
        hold_nxt = (hold_load != '0) ? hold_load - 1'b1 : hold_load;
        prev_nxt = !in_button_pin_level;
        edge_nxt = !in_button_pin_level && !prev_r;
      end
      psmd_pkg::OP_RESET: begin
        hold_nxt = '0;
        base_nxt = smooth_r;
      end
      psmd_pkg::OP_ARM: begin
        smooth_nxt[0] = in_sample_p1;
        smooth_nxt[1] = in_sample_p2;
        base_nxt[0]   = in_sample_p1;
        base_nxt[1]   = in_sample_p2;
      end
      default: begin
      end
    endcase
  end

  psmd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .value  (s1_value_r),
    .range  (range_r),
    .paddle (paddle)
  );

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= psmd_pkg::THRESH_RESET;
      hold_frames_r <= psmd_pkg::HOLD_RESET;
      range_r       <= psmd_pkg::RANGE_RESET;
      smooth_r[0]   <= SAMPLE_MID;
      smooth_r[1]   <= SAMPLE_MID;
      base_r[0]     <= SAMPLE_MID;
      base_r[1]     <= SAMPLE_MID;
      hold_r        <= '0;
      mover_r       <= 1'b0;
      prev_r        <= 1'b0;
      edge_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          psmd_pkg::CFG_MOVE_THRESHOLD: thresh_r <= cfg_data[psmd_pkg::THRESH_W-1:0];
          psmd_pkg::CFG_HOLD_FRAMES:    hold_frames_r <= cfg_data[psmd_pkg::HOLD_W-1:0];
          psmd_pkg::CFG_PADDLE_RANGE:   range_r <= cfg_data[psmd_pkg::RANGE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        smooth_r <= smooth_nxt;
        base_r   <= base_nxt;
        hold_r   <= hold_nxt;
        mover_r  <= mover_nxt;
        prev_r   <= prev_nxt;
        edge_r   <= edge_nxt;
      end
    end
  end

  // stage 1 and output beat control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value_r <= in_query_player ? smooth_nxt[1] : smooth_nxt[0];
      s1_move_r  <= hold_nxt != '0;
      s1_mover_r <= mover_nxt;
      s1_edge_r  <= edge_nxt;
    end
    if (s2_adv && s1_valid_r) begin
      out_value_r  <= s1_value_r;
      out_paddle_r <= paddle;
      out_move_r   <= s1_move_r;
      out_mover_r  <= s1_mover_r;
      out_edge_r   <= s1_edge_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_smoothed_value    = out_value_r;
  assign out_paddle_y          = out_paddle_r;
  assign out_movement_detected = out_move_r;
  assign out_last_mover        = out_mover_r;
  assign out_press_edge        = out_edge_r;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the pot smoothing motion detector, predicting every result beat.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned SAMPLE_MID = 1 << (SAMPLE_W - 1);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [psmd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 10;
  localparam int SETTING_SPAN   = 150;

  typedef struct packed {
    logic [1:0]          op;
    logic [SAMPLE_W-1:0] sample_p1;
    logic [SAMPLE_W-1:0] sample_p2;
    logic                pin;
    logic                query;
  } pot_beat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]          value;
    logic [psmd_pkg::FIELD_W-1:0] paddle;
    logic                         moving;
    logic                         mover;
    logic                         press;
  } pot_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_operation = psmd_pkg::OP_POLL;
  logic [SAMPLE_W-1:0]    in_sample_p1 = '0;
  logic [SAMPLE_W-1:0]    in_sample_p2 = '0;
  logic                   in_button_pin_level = 1'b1;
  logic                   in_query_player = 1'b0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_W-1:0]    out_smoothed_value;
  logic [psmd_pkg::FIELD_W-1:0] out_paddle_y;
  logic                   out_movement_detected;
  logic                   out_last_mover;
  logic                   out_press_edge;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [psmd_pkg::CFG_INDEX_W-1:0] cfg_index = psmd_pkg::CFG_MOVE_THRESHOLD;
  logic [psmd_pkg::FIELD_W-1:0]     cfg_data = '0;

  // Predicted detector state and register shadows
  logic [SAMPLE_W-1:0] est_smooth [2] = '{SAMPLE_MID, SAMPLE_MID};
  logic [SAMPLE_W-1:0] est_base   [2] = '{SAMPLE_MID, SAMPLE_MID};
  logic [psmd_pkg::HOLD_W-1:0]   est_hold = '0;
  logic                est_mover = 1'b0;
  logic                est_prev_pressed = 1'b0;
  logic                est_press = 1'b0;
  logic [psmd_pkg::THRESH_W-1:0] thr_reg = psmd_pkg::THRESH_RESET;
  logic [psmd_pkg::HOLD_W-1:0]   hold_reg = psmd_pkg::HOLD_RESET;
  logic [psmd_pkg::RANGE_W-1:0]  range_reg = psmd_pkg::RANGE_RESET;

  pot_report_t expected_reports [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  logic pin_level = 1'b1;

  pot_smoothing_motion_detector #(.SAMPLE_BITS(SAMPLE_W)) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_sample_p1          (in_sample_p1),
    .in_sample_p2          (in_sample_p2),
    .in_button_pin_level   (in_button_pin_level),
    .in_query_player       (in_query_player),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_smoothed_value    (out_smoothed_value),
    .out_paddle_y          (out_paddle_y),
    .out_movement_detected (out_movement_detected),
    .out_last_mover        (out_last_mover),
    .out_press_edge        (out_press_edge),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter both channels, detect movement and the press edge, report the queried channel.
  function automatic pot_report_t advance_detector(pot_beat_t b);
    pot_report_t         r;
    logic [SAMPLE_W-1:0] samp [2];
    int unsigned         filt;
    int unsigned         diff;
    int unsigned         prod;
    logic                now_pressed;
    samp[0] = b.sample_p1;
    samp[1] = b.sample_p2;
    case (b.op)
      psmd_pkg::OP_POLL: begin
        // channel 1 runs second, so it wins ties for last mover
        for (int ch = 0; ch < 2; ch++) begin
          filt = (est_smooth[ch] * psmd_pkg::SMOOTH_WEIGHT + samp[ch]) /
                 (psmd_pkg::SMOOTH_WEIGHT + 1);
          diff = (filt >= est_base[ch]) ? filt - est_base[ch] : est_base[ch] - filt;
          est_smooth[ch] = filt[SAMPLE_W-1:0];
          if (diff > thr_reg) begin
            est_hold = hold_reg;
            est_mover = (ch == 1);
            est_base[ch] = est_smooth[ch];
          end
        end
        if (est_hold != 0) est_hold = est_hold - 1'b1;
        now_pressed = ~b.pin;
        est_press = now_pressed & ~est_prev_pressed;
        est_prev_pressed = now_pressed;
      end
      psmd_pkg::OP_RESET: begin
        est_hold = '0;
        est_base[0] = est_smooth[0];
        est_base[1] = est_smooth[1];
      end
      psmd_pkg::OP_ARM: begin
        est_smooth[0] = samp[0];
        est_smooth[1] = samp[1];
        est_base[0] = samp[0];
        est_base[1] = samp[1];
      end
      default: ;
    endcase
    r.value = est_smooth[b.query];
    prod = r.value * range_reg;
    prod = prod / psmd_pkg::FULL_SCALE;
    r.paddle = prod[psmd_pkg::FIELD_W-1:0];
    r.moving = (est_hold != 0);
    r.mover = est_mover;
    r.press = est_press;
    return r;
  endfunction

  function automatic pot_beat_t beat(logic [1:0] op, int unsigned s1, int unsigned s2,
                                     logic pin, logic query);
    pot_beat_t b;
    b.op = op;
    b.sample_p1 = s1[SAMPLE_W-1:0];
    b.sample_p2 = s2[SAMPLE_W-1:0];
    b.pin = pin;
    b.query = query;
    return b;
  endfunction

  // Half the picks are steps around the current level so the hold counter gets to run down.
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] level);
    int span;
    int v;
    case ($urandom_range(2))
      0:       span = 4;
      1:       span = 48;
      default: span = 400;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        v = int'(level) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
      end
      8:       v = 0;
      9:       v = SAMPLE_MAX;
      default: v = $urandom_range(SAMPLE_MAX);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic pot_beat_t make_random_beat();
    pot_beat_t   b;
    int unsigned pick;
    int unsigned q;
    pick = $urandom_range(99);
    if (pick < 75) b.op = psmd_pkg::OP_POLL;
    else if (pick < 86) b.op = psmd_pkg::OP_RESET;
    else if (pick < 96) b.op = psmd_pkg::OP_ARM;
    else b.op = OP_UNUSED;
    b.sample_p1 = pick_sample(est_smooth[0]);
    b.sample_p2 = pick_sample(est_smooth[1]);
    if ($urandom_range(99) < 30) pin_level = ~pin_level;
    b.pin = pin_level;
    q = $urandom_range(1);
    b.query = q[0];
    return b;
  endfunction

  task automatic send_item(pot_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= b.op;
    in_sample_p1 <= b.sample_p1;
    in_sample_p2 <= b.sample_p2;
    in_button_pin_level <= b.pin;
    in_query_player <= b.query;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(advance_detector(b));
  endtask

  // Drop valid and hold until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [psmd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [psmd_pkg::FIELD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      psmd_pkg::CFG_MOVE_THRESHOLD: thr_reg = data[psmd_pkg::THRESH_W-1:0];
      psmd_pkg::CFG_HOLD_FRAMES:    hold_reg = data[psmd_pkg::HOLD_W-1:0];
      psmd_pkg::CFG_PADDLE_RANGE:   range_reg = data[psmd_pkg::RANGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_detector(int unsigned thr, int unsigned hold, int unsigned range);
    drain();
    write_reg(psmd_pkg::CFG_MOVE_THRESHOLD, thr[psmd_pkg::FIELD_W-1:0]);
    write_reg(psmd_pkg::CFG_HOLD_FRAMES, hold[psmd_pkg::FIELD_W-1:0]);
    write_reg(psmd_pkg::CFG_PADDLE_RANGE, range[psmd_pkg::FIELD_W-1:0]);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    send_item(beat(psmd_pkg::OP_POLL, SAMPLE_MID, SAMPLE_MID, 1'b1, 1'b0));
    send_item(beat(OP_UNUSED, 0, SAMPLE_MAX, 1'b0, 1'b1));
    // both channels move at once, channel 1 takes last mover; first press
    send_item(beat(psmd_pkg::OP_POLL, SAMPLE_MAX, 0, 1'b0, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, SAMPLE_MAX, 0, 1'b0, 1'b1));
    send_item(beat(psmd_pkg::OP_RESET, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 0, SAMPLE_MAX, 1'b1, 1'b1));
    send_item(beat(psmd_pkg::OP_ARM, 0, SAMPLE_MAX, 1'b0, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 0, SAMPLE_MAX, 1'b0, 1'b1));
    send_item(beat(psmd_pkg::OP_ARM, SAMPLE_MAX, 0, 1'b1, 1'b1));
    send_item(beat(psmd_pkg::OP_POLL, SAMPLE_MAX, 0, 1'b1, 1'b0));
    // zero hold frames, upper data bits set; zero threshold; full-scale paddle
    set_detector(0, 12'hfc0, SAMPLE_MAX);
    send_item(beat(psmd_pkg::OP_POLL, 0, 0, 1'b1, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 0, 0, 1'b0, 1'b1));
    // a hold of one frame expires in the same poll; zero paddle range
    set_detector(0, 1, 0);
    send_item(beat(psmd_pkg::OP_POLL, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1));
    // maximum threshold: nothing can count as movement
    set_detector(SAMPLE_MAX, 63, 1);
    send_item(beat(psmd_pkg::OP_POLL, 0, 0, 1'b1, 1'b0));
    send_item(beat(psmd_pkg::OP_ARM, SAMPLE_MAX, 0, 1'b1, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 0, SAMPLE_MAX, 1'b0, 1'b1));
    set_detector(1, 63, SAMPLE_MAX);
    write_reg(CFG_UNUSED, 12'hfff);
    send_item(beat(psmd_pkg::OP_POLL, 1000, 3000, 1'b1, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 1000, 3000, 1'b1, 1'b1));
    send_item(beat(psmd_pkg::OP_RESET, 0, 0, 1'b0, 1'b0));
    send_item(beat(psmd_pkg::OP_POLL, 1000, 3000, 1'b0, 1'b1));
    drain();
  endtask

  task automatic test_random_traffic(int send_idle, int recv_stall, int count);
    int unsigned thr;
    int unsigned hold;
    int unsigned range;
    send_idle_pct = send_idle;
    recv_stall_pct <= recv_stall;
    for (int i = 0; i < count; i++) begin
      if (i % SETTING_SPAN == 0) begin
        case ($urandom_range(7))
          0, 1:    thr = 0;
          2:       thr = SAMPLE_MAX;
          default: thr = $urandom_range(1, 400);
        endcase
        case ($urandom_range(9))
          0:       hold = 0;
          1:       hold = 63;
          2:       hold = 1;
          default: hold = $urandom_range(2, 62);
        endcase
        case ($urandom_range(6))
          0:       range = 0;
          1:       range = SAMPLE_MAX;
          default: range = $urandom_range(SAMPLE_MAX);
        endcase
        set_detector(thr, ($urandom_range(63) << psmd_pkg::HOLD_W) | hold, range);
      end
      send_item(make_random_beat());
    end
    drain();
  endtask

  // Block the output long enough for the pipeline to fill and stall the input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    stall_req <= stall_req + 1;
    for (int i = 0; i < 40; i++) send_item(make_random_beat());
    drain();
  endtask

  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pot_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no pending expectation");
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("smoothed_value", want.value, out_smoothed_value);
        check_field("paddle_y", want.paddle, out_paddle_y);
        check_field("movement_detected", want.moving, out_movement_detected);
        check_field("last_mover", want.mover, out_last_mover);
        check_field("press_edge", want.press, out_press_edge);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(0, 0, 490);
    test_output_backpressure();
    test_random_traffic(74, 0, 490);
    test_random_traffic(0, 74, 490);
    test_random_traffic(22, 22, 490);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected beats never arrived", expected_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
